// ===== hw/rtl/kbpsh_pkg.sv =====
// Shared constants, codes and tables for the keyed byte-permute signature hash.
package kbpsh_pkg;

    localparam int unsigned WORD_W      = 64;
    localparam int unsigned OP_W        = 3;
    localparam int unsigned FLAG_W      = 4;
    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 72;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_INPUT   = 3'd0,
        OP_ADD_OUTPUT  = 3'd1,
        OP_ADD_SETTING = 3'd2,
        OP_ADD_FLAG    = 3'd3,
        OP_RESTART     = 3'd4
    } op_t;

    // flag codes below FLAG_HASHED_COUNT fold a fixed word into the hash
    localparam logic [FLAG_W-1:0] FLAG_HASHED_COUNT = 4'd6;
    localparam logic [FLAG_W-1:0] FLAG_DEPRECATED   = 4'd6;
    localparam logic [FLAG_W-1:0] FLAG_UNSTABLE     = 4'd7;

    localparam word_t HASH_START_RESET = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam word_t INPUT_KEY_INIT   = 64'h64AC_3CB5_4A35_888C;
    localparam word_t OUTPUT_KEY_INIT  = 64'h21E0_FAAF_E5CA_F1E1;
    localparam word_t SETTING_KEY_INIT = 64'h6BDF_B15B_54B0_9F63;
    localparam word_t INPUT_KEY_STIR   = 64'h7936_A0F3_BD12_D936;
    localparam word_t OUTPUT_KEY_STIR  = 64'hCBB6_6A5B_893A_A4E9;
    localparam word_t SETTING_KEY_STIR = 64'h3C87_F3AA_E9F8_303B;

    function automatic word_t flag_word(input logic [2:0] code);
        word_t w;
        case (code)
            3'd0:    w = 64'h0750_7AC8_EB64_3ACE;
            3'd1:    w = 64'h5C98_5376_8D74_CDB8;
            3'd2:    w = 64'h58DE_A69B_1241_1365;
            3'd3:    w = 64'h6E16_2C01_AC97_9F22;
            3'd4:    w = 64'hFA7A_50DC_2140_C013;
            3'd5:    w = 64'h624D_7661_D8DD_EA0A;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/kbpsh_permute.sv =====
// Keyed byte permutation: four sequential byte swaps chosen by the key's byte pairs.
module kbpsh_permute (
    input  kbpsh_pkg::word_t value,
    input  kbpsh_pkg::word_t key,
    output kbpsh_pkg::word_t result
);

    always_comb begin
        logic [7:0] b [8];
        logic [2:0] j;
        logic [2:0] k;
        logic [7:0] t;
        for (int i = 0; i < 8; i++) begin
            b[i] = value[8*i +: 8];
        end
        // swap i uses key bytes 2i and 2i+1, low three bits of each
        for (int s = 0; s < 4; s++) begin
            j    = key[16*s +: 3];
            k    = key[16*s + 8 +: 3];
            t    = b[j];
            b[j] = b[k];
            b[k] = t;
        end
        for (int i = 0; i < 8; i++) begin
            result[8*i +: 8] = b[i];
        end
    end

endmodule

// ===== hw/rtl/keyed_byte_permute_signature_hash_core.sv =====
// Top level of the keyed byte-permute signature hash core.
// Folds a stream of declaration requests (input, output, setting, flag, restart) into a
// 64-bit signature. One request is taken every cycle unless a full result register waits
// on m_tready. Each result appears on m_tvalid once its request has passed the input
// register, then the execute stage that updates the signature, the three kind keys and
// the sticky marks and loads the result register; its hash and key update is combinational.
// hash_start is loaded into the signature at reset and at each restart request only.
module keyed_byte_permute_signature_hash_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [kbpsh_pkg::IN_TDATA_W-1:0]    s_tdata,   // [63:0] type_id,
                                                           // [67:64] flag_code, [71:68] zero
    input  logic [2:0]                          s_tuser,   // [2:0] operation
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [kbpsh_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [0] accepted, [64:1] signature,
                                                           // [65] is_deprecated,
                                                           // [66] is_unstable, [71:67] zero
    input  logic                                cfg_wr_en,
    input  logic [63:0]                         cfg_wr_data
);

    // input register
    logic                                in_valid_reg;
    logic [kbpsh_pkg::OP_W-1:0]          op_reg;
    kbpsh_pkg::word_t                    type_id_reg;
    logic [kbpsh_pkg::FLAG_W-1:0]        flag_reg;

    // state
    kbpsh_pkg::word_t hash_start_reg;
    kbpsh_pkg::word_t hash_acc_reg,    hash_acc_next;
    kbpsh_pkg::word_t input_key_reg,   input_key_next;
    kbpsh_pkg::word_t output_key_reg,  output_key_next;
    kbpsh_pkg::word_t setting_key_reg, setting_key_next;
    logic             dep_mark_reg,    dep_mark_next;
    logic             unst_mark_reg,   unst_mark_next;
    logic             accepted_next;

    // result register
    logic                                out_valid_reg;
    logic [kbpsh_pkg::OUT_TDATA_W-1:0]   out_data_reg;

    logic             advance;
    logic             execute;
    kbpsh_pkg::word_t sel_key;
    kbpsh_pkg::word_t sel_stir;
    kbpsh_pkg::word_t id_perm;
    kbpsh_pkg::word_t key_perm;

    assign advance  = !out_valid_reg || m_tready;
    assign execute  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        case (op_reg)
            kbpsh_pkg::OP_ADD_OUTPUT: begin
                sel_key  = output_key_reg;
                sel_stir = kbpsh_pkg::OUTPUT_KEY_STIR;
            end
            kbpsh_pkg::OP_ADD_SETTING: begin
                sel_key  = setting_key_reg;
                sel_stir = kbpsh_pkg::SETTING_KEY_STIR;
            end
            default: begin
                sel_key  = input_key_reg;
                sel_stir = kbpsh_pkg::INPUT_KEY_STIR;
            end
        endcase
    end

    kbpsh_permute u_id_permute (
        .value  (type_id_reg),
        .key    (sel_key),
        .result (id_perm)
    );

    kbpsh_permute u_key_permute (
        .value  (sel_key),
        .key    (sel_stir),
        .result (key_perm)
    );

    always_comb begin
        hash_acc_next    = hash_acc_reg;
        input_key_next   = input_key_reg;
        output_key_next  = output_key_reg;
        setting_key_next = setting_key_reg;
        dep_mark_next    = dep_mark_reg;
        unst_mark_next   = unst_mark_reg;
        accepted_next    = 1'b1;
        case (op_reg)
            kbpsh_pkg::OP_ADD_INPUT: begin
                hash_acc_next  = hash_acc_reg ^ id_perm;
                input_key_next = key_perm;
            end
            kbpsh_pkg::OP_ADD_OUTPUT: begin
                hash_acc_next   = hash_acc_reg ^ id_perm;
                output_key_next = key_perm;
            end
            kbpsh_pkg::OP_ADD_SETTING: begin
                hash_acc_next    = hash_acc_reg ^ id_perm;
                setting_key_next = key_perm;
            end
            kbpsh_pkg::OP_ADD_FLAG: begin
                if (flag_reg < kbpsh_pkg::FLAG_HASHED_COUNT) begin
                    hash_acc_next = hash_acc_reg ^ kbpsh_pkg::flag_word(flag_reg[2:0]);
                end else if (flag_reg == kbpsh_pkg::FLAG_DEPRECATED) begin
                    dep_mark_next = 1'b1;
                end else if (flag_reg == kbpsh_pkg::FLAG_UNSTABLE) begin
                    unst_mark_next = 1'b1;
                end else begin
                    accepted_next = 1'b0;
                end
            end
            kbpsh_pkg::OP_RESTART: begin
                hash_acc_next    = hash_start_reg;
                input_key_next   = kbpsh_pkg::INPUT_KEY_INIT;
                output_key_next  = kbpsh_pkg::OUTPUT_KEY_INIT;
                setting_key_next = kbpsh_pkg::SETTING_KEY_INIT;
                dep_mark_next    = 1'b0;
                unst_mark_next   = 1'b0;
            end
            default: begin
                // unknown operation: state untouched, request still accepted
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            hash_start_reg  <= kbpsh_pkg::HASH_START_RESET;
            hash_acc_reg    <= kbpsh_pkg::HASH_START_RESET;
            input_key_reg   <= kbpsh_pkg::INPUT_KEY_INIT;
            output_key_reg  <= kbpsh_pkg::OUTPUT_KEY_INIT;
            setting_key_reg <= kbpsh_pkg::SETTING_KEY_INIT;
            dep_mark_reg    <= 1'b0;
            unst_mark_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                hash_start_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (execute) begin
                hash_acc_reg    <= hash_acc_next;
                input_key_reg   <= input_key_next;
                output_key_reg  <= output_key_next;
                setting_key_reg <= setting_key_next;
                dep_mark_reg    <= dep_mark_next;
                unst_mark_reg   <= unst_mark_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            op_reg      <= s_tuser;
            type_id_reg <= s_tdata[63:0];
            flag_reg    <= s_tdata[67:64];
        end
        if (execute) begin
            out_data_reg <= {5'b0, unst_mark_next, dep_mark_next, hash_acc_next,
                             accepted_next};
        end
    end

endmodule
